/* sv/flywheel_balance_torque_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the flywheel balance torque controller
// Shared forms for concurrent checks, one macro per kind of implication.
// ----------------------------------------------------------------------------
`ifndef FLYWHEEL_BALANCE_TORQUE_CONTROLLER_ASSERT_SVH
`define FLYWHEEL_BALANCE_TORQUE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FBTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FBTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked in reset too
`define FBTC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fbtc_pkg.sv */
// ----------------------------------------------------------------------------
// fbtc_pkg
// Types, constants and tables shared by the torque controller modules.
// ----------------------------------------------------------------------------
package fbtc_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int ROOT_ITER_DEF    = 32;
    localparam int CORDIC_STEPS     = 30;
    localparam int CFG_W            = 32;

    localparam logic signed [39:0] PI_Q30      = 40'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] QRTR_PI_Q30 = 64'sd843314857;

    // Q30 angle constants brought to the output fraction, rounded half up
    localparam logic signed [31:0] HALF_PI_F =
        32'((HALF_PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    localparam logic [31:0] QRTR_PI_F =
        32'((QRTR_PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

    // Leg extension threshold, 0.001 rounded
    localparam logic signed [31:0] EFFORT_THRESH =
        32'(((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);

    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ANGLE_GAIN    = 3'd0,
        REG_RATE_GAIN     = 3'd1,
        REG_STALL_TORQUE  = 3'd2,
        REG_NO_LOAD_SPEED = 3'd3,
        REG_GRAVITY       = 3'd4,
        REG_ARM_LEN       = 3'd5,
        REG_TAKEOFF_GAIN  = 3'd6,
        REG_SPEED_EPS     = 3'd7
    } cfg_reg_t;

    // Operations of the shared root and divide unit
    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            5'd24: v = 32'd63;
            5'd25: v = 32'd31;
            5'd26: v = 32'd15;
            5'd27: v = 32'd7;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/fbtc_iter.sv */
// ----------------------------------------------------------------------------
// fbtc_iter
// Shared bit-serial unit: 64-bit floor square root (32 steps) or
// 64 by 32 bit unsigned division (64 steps), one bit per cycle.
// ----------------------------------------------------------------------------
module fbtc_iter import fbtc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  unit_op_t    op,
    input  logic [63:0] opa,
    input  logic [31:0] opd,
    output unit_sts_t   sts,
    output logic [63:0] result
);

    logic        busy_reg, done_reg;
    unit_op_t    op_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg;   // root: remaining radicand; divide: numerator / quotient
    logic [63:0] aux_reg;   // root: partial root; divide: remainder
    logic [63:0] bit_reg;
    logic [31:0] dvs_reg;

    logic [63:0] sq_trial;
    logic        sq_ge;
    logic [32:0] dv_shift;
    logic [33:0] dv_diff;
    logic        dv_ge;
    logic        last;

    // One root step and one restoring divide step
    always_comb begin
        sq_trial = aux_reg + bit_reg;
        sq_ge    = acc_reg >= sq_trial;
        dv_shift = {aux_reg[31:0], acc_reg[63]};
        dv_diff  = {1'b0, dv_shift} - {2'b00, dvs_reg};
        dv_ge    = !dv_diff[33];
        last     = (op_reg == OP_SQRT) ? (cnt_reg == 6'd31) : (cnt_reg == 6'd63);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg  <= op;
            cnt_reg <= '0;
            acc_reg <= opa;
            aux_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
            dvs_reg <= opd;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            case (op_reg)
                OP_SQRT: begin
                    if (sq_ge) begin
                        acc_reg <= acc_reg - sq_trial;
                        aux_reg <= (aux_reg >> 1) + bit_reg;
                    end else begin
                        aux_reg <= aux_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                OP_DIV: begin
                    acc_reg <= {acc_reg[62:0], dv_ge};
                    aux_reg <= dv_ge ? {32'd0, dv_diff[31:0]} : {31'd0, dv_shift};
                end
                default: begin
                    aux_reg <= aux_reg;
                end
            endcase
        end
    end

    assign sts    = '{busy: busy_reg, done: done_reg};
    assign result = (op_reg == OP_SQRT) ? aux_reg : acc_reg;

endmodule

/* sv/fbtc_cordic.sv */
// ----------------------------------------------------------------------------
// fbtc_cordic
// Iterative vectoring CORDIC: atan2(y, x), one rotation per cycle,
// Q30 angle accumulator rounded to the output fraction.
// ----------------------------------------------------------------------------
module fbtc_cordic import fbtc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [35:0] y_in,
    input  logic signed [35:0] x_in,
    output unit_sts_t          sts,
    output logic signed [31:0] angle
);

    logic               busy_reg, done_reg, zero_reg;
    logic [4:0]         cnt_reg;
    logic signed [47:0] x_reg, y_reg;
    logic signed [39:0] z_reg;

    logic signed [36:0] xs, ys;
    logic signed [39:0] z0;
    logic signed [47:0] dx, dy;
    logic signed [39:0] at_ext;
    logic signed [39:0] z_rnd;

    // Fold the left half plane and form one rotation
    always_comb begin
        xs     = x_in[35] ? -37'(x_in) : 37'(x_in);
        ys     = x_in[35] ? -37'(y_in) : 37'(y_in);
        z0     = x_in[35] ? (y_in[35] ? -PI_Q30 : PI_Q30) : 40'sd0;
        dx     = y_reg >>> cnt_reg;
        dy     = x_reg >>> cnt_reg;
        at_ext = $signed({8'd0, atan_q30(cnt_reg)});
        z_rnd  = (z_reg + (40'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Rotate towards the x axis
    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg  <= '0;
            zero_reg <= (x_in == 36'sd0) && (y_in == 36'sd0);
            x_reg    <= 48'(xs) <<< 8;
            y_reg    <= 48'(ys) <<< 8;
            z_reg    <= z0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (y_reg > 48'sd0) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at_ext;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at_ext;
            end
        end
    end

    assign sts   = '{busy: busy_reg, done: done_reg};
    assign angle = zero_reg ? 32'sd0 : z_rnd[31:0];

endmodule

/* sv/flywheel_balance_torque_controller.sv */
// ----------------------------------------------------------------------------
// flywheel_balance_torque_controller
// Flywheel torque command from one pendulum sensor sample per transaction.
// ----------------------------------------------------------------------------
// One sample is taken when s_tready is high; s_tready stays low until its
// torque command has been placed in the output register. A sample on the
// ground is quicker than one with the leg extending, where the track offset
// has to be divided. Airborne, the landing prediction adds apex work,
// ROOT_ITERATIONS passes of the landing loop and an atan2, all paced by the
// bit-serial root and divide unit that every square root and division goes
// through one bit per cycle. A 30-step CORDIC serves both atan2 evaluations
// and one registered multiplier all products.
// The landing angle is kept between samples; reset clears it to zero.
// ----------------------------------------------------------------------------
module flywheel_balance_torque_controller import fbtc_pkg::*; #(
    parameter int ROOT_ITERATIONS = ROOT_ITER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // quat_x[17:0] quat_w[35:18] arm_rate[67:36] flywheel_rate[99:68]
    // body_vel_y[131:100] body_vel_z[163:132] body_pos_z[195:164]
    // body_pos_y[227:196] track_pos_y[259:228] ground_contact[260]
    // joints_valid[261] leg_effort[293:262], zero fill[295:294]
    input  logic [295:0]      s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // torque_command[31:0]
    output logic [31:0]       m_tdata,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int LW = $clog2(ROOT_ITERATIONS + 1);

    typedef enum logic [29:0] {
        ST_IDLE    = 30'd1 << 0,
        ST_RADSQ   = 30'd1 << 1,
        ST_RADRT   = 30'd1 << 2,
        ST_ATANA   = 30'd1 << 3,
        ST_ANGLE   = 30'd1 << 4,
        ST_VZ2     = 30'd1 << 5,
        ST_FALL    = 30'd1 << 6,
        ST_APEX    = 30'd1 << 7,
        ST_AVH2    = 30'd1 << 8,
        ST_H0MUL   = 30'd1 << 9,
        ST_H0RT    = 30'd1 << 10,
        ST_VZF     = 30'd1 << 11,
        ST_VZFSQ   = 30'd1 << 12,
        ST_NORM    = 30'd1 << 13,
        ST_TERMMUL = 30'd1 << 14,
        ST_TERMDIV = 30'd1 << 15,
        ST_DIST    = 30'd1 << 16,
        ST_DMUL    = 30'd1 << 17,
        ST_DRT     = 30'd1 << 18,
        ST_ATANL   = 30'd1 << 19,
        ST_LAND    = 30'd1 << 20,
        ST_OFFS    = 30'd1 << 21,
        ST_OFFQ    = 30'd1 << 22,
        ST_ACC1    = 30'd1 << 23,
        ST_ACC2    = 30'd1 << 24,
        ST_CMD     = 30'd1 << 25,
        ST_LIM     = 30'd1 << 26,
        ST_LIMDIV  = 30'd1 << 27,
        ST_OUT     = 30'd1 << 28,
        ST_WAIT    = 30'd1 << 29
    } state_t;

    state_t state_reg, ret_reg;

    // Configuration registers
    logic signed [31:0] angle_gain_reg, rate_gain_reg;
    logic [30:0] stall_reg, nls_reg, grav_reg, arm_reg, tkg_reg, eps_reg;

    // Sample fields
    logic               qx_neg_reg;
    logic signed [17:0] qw_reg;
    logic signed [31:0] arm_rate_reg, fly_reg, vy_reg, vz_reg, pz_reg, py_reg, ty_reg;
    logic signed [31:0] effort_reg;
    logic               contact_reg, joints_reg;

    // Working registers
    logic signed [31:0] angle_reg, offset_reg, landing_reg;
    logic [30:0]        pzmax_reg, h0_reg;
    logic [31:0]        avh_reg, vzf_reg, norm_reg, d_reg;
    logic [63:0]        avh2_reg, prod_reg, acca_reg;
    logic signed [47:0] cmd_reg;
    logic               lim_zero_reg;
    logic [LW-1:0]      loop_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    // Shared units
    logic               it_start, cor_start;
    unit_op_t           it_op;
    logic [63:0]        it_a, it_res;
    logic [31:0]        it_d;
    unit_sts_t          it_sts, cor_sts;
    logic signed [35:0] cor_y, cor_x;
    logic signed [31:0] cor_angle;

    // Multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;

    // Combinational helpers
    logic signed [17:0] qw_in;
    logic [31:0]        vz_abs, vy_abs, fly_abs;
    logic [30:0]        q_c;
    logic signed [32:0] pzmax_c;
    logic [30:0]        pzmax_s;
    logic [31:0]        term_c;
    logic signed [32:0] dist_c;
    logic signed [32:0] delta_c;
    logic [32:0]        ad_c;
    logic [31:0]        m_c;
    logic               takeoff_c;
    logic signed [63:0] sum_c;
    logic signed [63:0] rnd_c;
    logic [47:0]        cmd_abs;
    logic [31:0]        limit_c, mag_c, res_c;

    always_comb begin
        qw_in = $signed(s_tdata[35:18]);
        if (qw_in > 18'sd65536) begin
            qw_in = 18'sd65536;
        end else if (qw_in < -18'sd65536) begin
            qw_in = -18'sd65536;
        end
        vz_abs  = vz_reg[31] ? 32'(-vz_reg) : 32'(vz_reg);
        vy_abs  = vy_reg[31] ? 32'(-vy_reg) : 32'(vy_reg);
        fly_abs = fly_reg[31] ? 32'(-fly_reg) : 32'(fly_reg);

        // Apex height, saturated
        q_c = (grav_reg == 31'd0 || it_res > {33'd0, SAT31}) ? SAT31 : it_res[30:0];
        pzmax_c = 33'(pz_reg) + $signed({2'b00, q_c});
        pzmax_s = (pzmax_c > $signed({2'b00, SAT31})) ? SAT31 : pzmax_c[30:0];

        // Distance still to fall at the current guess
        term_c = (norm_reg == 32'd0) ? 32'd0 : it_res[31:0];
        dist_c = $signed({2'b00, pzmax_reg}) - $signed({1'b0, term_c});
        delta_c = 33'(ty_reg) - 33'(py_reg);
        ad_c    = delta_c[32] ? 33'(-delta_c) : 33'(delta_c);
        m_c     = (tkg_reg == 31'd0 || it_res >= {32'd0, QRTR_PI_F}) ? QRTR_PI_F
                                                                   : it_res[31:0];
        takeoff_c = contact_reg && joints_reg && (effort_reg > EFFORT_THRESH);

        // Command rounding and torque-speed saturation
        sum_c   = $signed(acca_reg) + $signed(prod_reg);
        rnd_c   = (sum_c + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        cmd_abs = cmd_reg[47] ? 48'(-cmd_reg) : 48'(cmd_reg);
        limit_c = lim_zero_reg ? 32'd0 : it_res[31:0];
        mag_c   = (cmd_abs > {16'd0, limit_c}) ? limit_c : cmd_abs[31:0];
        if (cmd_reg > 48'sd0) begin
            res_c = mag_c;
        end else if (cmd_reg < 48'sd0) begin
            res_c = 32'(-mag_c);
        end else begin
            res_c = 32'd0;
        end
    end

    // Operand selection for the multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RADSQ: begin
                mul_a = 34'(qw_reg);
                mul_b = 34'(qw_reg);
            end
            ST_VZ2: begin
                mul_a = $signed({2'b00, vz_abs});
                mul_b = $signed({2'b00, vz_abs});
            end
            ST_AVH2: begin
                mul_a = $signed({2'b00, avh_reg});
                mul_b = $signed({2'b00, avh_reg});
            end
            ST_H0MUL: begin
                mul_a = $signed({2'b00, grav_reg, 1'b0});
                mul_b = $signed({3'b000, h0_reg});
            end
            ST_VZFSQ: begin
                mul_a = $signed({2'b00, vzf_reg});
                mul_b = $signed({2'b00, vzf_reg});
            end
            ST_TERMMUL: begin
                mul_a = $signed({2'b00, vzf_reg});
                mul_b = $signed({3'b000, arm_reg});
            end
            ST_DMUL: begin
                mul_a = $signed({2'b00, grav_reg, 1'b0});
                mul_b = $signed({2'b00, d_reg});
            end
            ST_ACC1: begin
                mul_a = 34'(angle_gain_reg);
                mul_b = 34'(angle_reg) + 34'(offset_reg);
            end
            ST_ACC2: begin
                mul_a = 34'(rate_gain_reg);
                mul_b = 34'(arm_rate_reg);
            end
            ST_LIM: begin
                mul_a = $signed({3'b000, stall_reg});
                mul_b = $signed({3'b000, 31'(nls_reg - fly_abs[30:0])});
            end
            default: begin
                mul_a = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Start requests to the shared units
    always_comb begin
        it_start  = 1'b0;
        it_op     = OP_SQRT;
        it_a      = prod_reg;
        it_d      = '0;
        cor_start = 1'b0;
        cor_y     = '0;
        cor_x     = '0;
        case (state_reg)
            ST_RADRT: begin
                it_start = 1'b1;
                it_a     = (64'd1 << (2 * FRAC_BITS)) - prod_reg;
            end
            ST_FALL: begin
                it_start = (grav_reg != 31'd0);
                it_op    = OP_DIV;
                it_d     = {grav_reg, 1'b0};
            end
            ST_H0RT, ST_DRT: begin
                it_start = 1'b1;
            end
            ST_NORM: begin
                it_start = 1'b1;
                it_a     = prod_reg + avh2_reg;
            end
            ST_TERMDIV: begin
                it_start = (norm_reg != 32'd0);
                it_op    = OP_DIV;
                it_d     = norm_reg;
            end
            ST_OFFS: begin
                it_start = takeoff_c && (tkg_reg != 31'd0);
                it_op    = OP_DIV;
                it_a     = 64'(ad_c) << FRAC_BITS;
                it_d     = {1'b0, tkg_reg};
            end
            ST_LIMDIV: begin
                it_start = 1'b1;
                it_op    = OP_DIV;
                it_d     = {1'b0, nls_reg};
            end
            ST_ATANA: begin
                cor_start = 1'b1;
                cor_y     = $signed({4'd0, it_res[31:0]});
                cor_x     = 36'(qw_reg);
            end
            ST_ATANL: begin
                cor_start = 1'b1;
                cor_y     = $signed({4'd0, vzf_reg});
                cor_x     = 36'(vy_reg);
            end
            default: begin
                it_start = 1'b0;
            end
        endcase
    end

    fbtc_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (it_start),
        .op      (it_op),
        .opa     (it_a),
        .opd     (it_d),
        .sts     (it_sts),
        .result  (it_res)
    );

    fbtc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .y_in    (cor_y),
        .x_in    (cor_x),
        .sts     (cor_sts),
        .angle   (cor_angle)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_gain_reg <= 32'sd65536;
            rate_gain_reg  <= 32'sd524;
            stall_reg      <= 31'd48038;
            nls_reg        <= 31'd80982835;
            grav_reg       <= 31'd642253;
            arm_reg        <= 31'd13107;
            tkg_reg        <= 31'd65536;
            eps_reg        <= 31'd66;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_ANGLE_GAIN:    angle_gain_reg <= $signed(cfg_wdata);
                REG_RATE_GAIN:     rate_gain_reg  <= $signed(cfg_wdata);
                REG_STALL_TORQUE:  stall_reg      <= cfg_wdata[30:0];
                REG_NO_LOAD_SPEED: nls_reg        <= cfg_wdata[30:0];
                REG_GRAVITY:       grav_reg       <= cfg_wdata[30:0];
                REG_ARM_LEN:       arm_reg        <= cfg_wdata[30:0];
                REG_TAKEOFF_GAIN:  tkg_reg        <= cfg_wdata[30:0];
                REG_SPEED_EPS:     eps_reg        <= cfg_wdata[30:0];
                default:           eps_reg        <= eps_reg;
            endcase
        end
    end

    // Product register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p[63:0];
    end

    // Sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            landing_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Load a new result when the output register is free, else drop a taken one
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_RADSQ;
                    end
                end
                ST_RADSQ:   state_reg <= ST_RADRT;
                ST_RADRT: begin
                    ret_reg   <= ST_ATANA;
                    state_reg <= ST_WAIT;
                end
                ST_ATANA: begin
                    ret_reg   <= ST_ANGLE;
                    state_reg <= ST_WAIT;
                end
                ST_ANGLE:   state_reg <= contact_reg ? ST_OFFS : ST_VZ2;
                ST_VZ2:     state_reg <= ST_FALL;
                ST_FALL: begin
                    ret_reg   <= ST_APEX;
                    state_reg <= (grav_reg == 31'd0) ? ST_APEX : ST_WAIT;
                end
                ST_APEX: begin
                    if (pzmax_c <= 33'sd0) begin
                        state_reg <= ST_OFFS;
                    end else if (vy_abs <= {1'b0, eps_reg}) begin
                        landing_reg <= '0;
                        state_reg   <= ST_OFFS;
                    end else begin
                        state_reg <= ST_AVH2;
                    end
                end
                ST_AVH2:    state_reg <= ST_H0MUL;
                ST_H0MUL:   state_reg <= ST_H0RT;
                ST_H0RT, ST_DRT: begin
                    ret_reg   <= ST_VZF;
                    state_reg <= ST_WAIT;
                end
                ST_VZF: begin
                    state_reg <= (loop_reg == LW'(ROOT_ITERATIONS)) ? ST_ATANL : ST_VZFSQ;
                end
                ST_VZFSQ:   state_reg <= ST_NORM;
                ST_NORM: begin
                    ret_reg   <= ST_TERMMUL;
                    state_reg <= ST_WAIT;
                end
                ST_TERMMUL: state_reg <= ST_TERMDIV;
                ST_TERMDIV: begin
                    ret_reg   <= ST_DIST;
                    state_reg <= (norm_reg == 32'd0) ? ST_DIST : ST_WAIT;
                end
                ST_DIST:    state_reg <= ST_DMUL;
                ST_DMUL:    state_reg <= ST_DRT;
                ST_ATANL: begin
                    ret_reg   <= ST_LAND;
                    state_reg <= ST_WAIT;
                end
                ST_LAND: begin
                    landing_reg <= cor_angle - HALF_PI_F;
                    state_reg   <= ST_OFFS;
                end
                ST_OFFS: begin
                    ret_reg <= ST_OFFQ;
                    if (!takeoff_c) begin
                        state_reg <= ST_ACC1;
                    end else if (tkg_reg == 31'd0) begin
                        state_reg <= ST_OFFQ;
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_OFFQ:    state_reg <= ST_ACC1;
                ST_ACC1:    state_reg <= ST_ACC2;
                ST_ACC2:    state_reg <= ST_CMD;
                ST_CMD:     state_reg <= ST_LIM;
                ST_LIM: begin
                    ret_reg <= ST_OUT;
                    if (nls_reg == 31'd0 || fly_abs >= {1'b0, nls_reg}) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_LIMDIV;
                    end
                end
                ST_LIMDIV:  state_reg <= ST_WAIT;
                ST_OUT: begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WAIT: begin
                    if (it_sts.done || cor_sts.done) begin
                        state_reg <= ret_reg;
                    end
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                qx_neg_reg   <= s_tdata[17];
                qw_reg       <= qw_in;
                arm_rate_reg <= $signed(s_tdata[67:36]);
                fly_reg      <= $signed(s_tdata[99:68]);
                vy_reg       <= $signed(s_tdata[131:100]);
                vz_reg       <= $signed(s_tdata[163:132]);
                pz_reg       <= $signed(s_tdata[195:164]);
                py_reg       <= $signed(s_tdata[227:196]);
                ty_reg       <= $signed(s_tdata[259:228]);
                contact_reg  <= s_tdata[260];
                joints_reg   <= s_tdata[261];
                effort_reg   <= $signed(s_tdata[293:262]);
            end
            ST_ANGLE: begin
                angle_reg <= qx_neg_reg ? -(cor_angle <<< 1) : (cor_angle <<< 1);
            end
            ST_APEX: begin
                pzmax_reg <= pzmax_s;
                avh_reg   <= vy_abs;
                h0_reg    <= pzmax_s - ((arm_reg < pzmax_s) ? arm_reg : pzmax_s);
            end
            ST_H0MUL: begin
                avh2_reg <= prod_reg;
            end
            ST_H0RT: begin
                loop_reg <= '0;
            end
            ST_DRT: begin
                loop_reg <= loop_reg + LW'(1);
            end
            ST_VZF: begin
                vzf_reg <= it_res[31:0];
            end
            ST_TERMMUL: begin
                norm_reg <= it_res[31:0];
            end
            ST_DIST: begin
                d_reg <= dist_c[32] ? 32'(-dist_c) : 32'(dist_c);
            end
            ST_OFFS: begin
                offset_reg <= landing_reg;
            end
            ST_OFFQ: begin
                offset_reg <= (delta_c > 33'sd0) ? $signed(m_c) : -$signed(m_c);
            end
            ST_ACC2: begin
                acca_reg <= prod_reg;
            end
            ST_CMD: begin
                cmd_reg <= rnd_c[47:0];
            end
            ST_LIM: begin
                lim_zero_reg <= (nls_reg == 31'd0) || (fly_abs >= {1'b0, nls_reg});
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= res_c;
                end
            end
            default: begin
                lim_zero_reg <= lim_zero_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/fbtc_checker.sv */
// ----------------------------------------------------------------------------
// fbtc_checker
// Port-level checks on the torque controller, bound to its top level.
// ----------------------------------------------------------------------------
`include "flywheel_balance_torque_controller_assert.svh"

module fbtc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [31:0]       m_tdata
);

    logic s_acc;
    assign s_acc = aresetn && s_tvalid && s_tready;

    // A stalled result transaction keeps its value
    `FBTC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset empties the output register
    `FBTC_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // One sample at a time: busy straight after a transaction is taken
    `FBTC_ASSERT_NEXT(a_busy_after, aclk, aresetn, s_acc, !s_tready, "ready right after accepting a sample")

    // No result appears in the cycle after a sample is taken
    `FBTC_ASSERT_NEXT(a_no_instant, aclk, aresetn, s_acc, !$rose(m_tvalid), "result too early")

endmodule

bind flywheel_balance_torque_controller fbtc_checker u_fbtc_checker (.*);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flywheel balance torque controller. It drives
// pendulum samples (grounded and airborne) under several register settings
// and random idling on both streams. It predicts each torque command, with its
// own copy of the landing angle and the registers, and compares every result
// transaction in order.
// ----------------------------------------------------------------------------
module tb;
    import fbtc_pkg::*;

    localparam longint ONE       = 64'sd1 <<< FRAC_BITS;
    localparam int     STALL_MAX = 40000;

    typedef struct {
        logic signed [17:0] qx, qw;
        logic signed [31:0] arm_rate, fly_rate, vel_y, vel_z, pos_z, pos_y, track_y;
        logic               contact, joints;
        logic signed [31:0] effort;
    } sample_t;

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [295:0] s_tdata;
    logic         m_tvalid, m_tready;
    logic [31:0]  m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    flywheel_balance_torque_controller dut (.*);

    // predictor state
    longint angle_gain, rate_gain, stall_torque, no_load_speed, gravity;
    longint arm_len, takeoff_gain, speed_epsilon, held_landing;

    logic [31:0] torque_queue[$];
    int          errors = 0;
    bit          quiet;
    int          stall_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // fixed-point helpers
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint q30_round(input longint v);
        return (v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic longint cordic_atan2(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
            end
        end
        return q30_round(z);
    endfunction

    // airborne: update the held landing angle from the ballistic apex
    function automatic void predict_landing(input longint vh, input longint vz,
                                            input longint pz);
        longint unsigned avz, t, vzf, nrm;
        longint apex_gain, apex, h0, avh, term, d;
        avz = (vz < 0) ? -vz : vz;
        if (gravity == 0) begin
            apex_gain = 64'sh7FFF_FFFF;
        end else begin
            t = (avz * avz) / (2 * longint'(gravity));
            apex_gain = (t > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(t);
        end
        apex = pz + apex_gain;
        if (apex > 64'sh7FFF_FFFF) apex = 64'sh7FFF_FFFF;
        if (apex <= 0) return;
        avh = (vh < 0) ? -vh : vh;
        if (avh <= speed_epsilon) begin
            held_landing = 0;
            return;
        end
        h0 = apex - ((arm_len < apex) ? arm_len : apex);
        vzf = int_sqrt(2 * gravity * h0);
        for (int i = 0; i < ROOT_ITER_DEF; i++) begin
            nrm  = int_sqrt(vzf * vzf + avh * avh);
            term = (nrm != 0) ? longint'(vzf * arm_len / nrm) : 0;
            d = apex - term;
            if (d < 0) d = -d;
            vzf = int_sqrt(2 * gravity * d);
        end
        held_landing = cordic_atan2(longint'(vzf), vh) - q30_round(HALF_PI_Q30);
    endfunction

    function automatic logic [31:0] torque_of(input sample_t s);
        longint qw, angle, offset, acc, cmd, lim, afly, mag, delta, ad, cap, m;
        longint unsigned t;
        qw = s.qw;
        if (qw > ONE) qw = ONE;
        if (qw < -ONE) qw = -ONE;
        angle = 2 * cordic_atan2(longint'(int_sqrt(ONE * ONE - qw * qw)), qw);
        if (s.qx < 0) angle = -angle;
        if (!s.contact) predict_landing(s.vel_y, s.vel_z, s.pos_z);
        if (s.contact && s.joints && s.effort > EFFORT_THRESH) begin
            delta = longint'(s.track_y) - longint'(s.pos_y);
            ad = (delta < 0) ? -delta : delta;
            cap = q30_round(QRTR_PI_Q30);
            m = cap;
            if (takeoff_gain != 0) begin
                t = (longint'(ad) <<< FRAC_BITS) / takeoff_gain;
                if (t < cap) m = longint'(t);
            end
            offset = (delta > 0) ? m : -m;
        end else begin
            offset = held_landing;
        end
        acc = angle_gain * (angle + offset) + rate_gain * longint'(s.arm_rate);
        cmd = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        afly = (s.fly_rate < 0) ? -longint'(s.fly_rate) : longint'(s.fly_rate);
        if (afly >= no_load_speed) lim = 0;
        else lim = stall_torque * (no_load_speed - afly) / no_load_speed;
        mag = (cmd < 0) ? -cmd : cmd;
        if (mag > lim) mag = lim;
        return 32'((cmd > 0) ? mag : ((cmd < 0) ? -mag : 0));
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge aclk);
    endtask

    task automatic send_sample(input sample_t s);
        idle_burst();
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, s.effort, s.joints, s.contact, s.track_y, s.pos_y, s.pos_z,
                     s.vel_z, s.vel_y, s.fly_rate, s.arm_rate, s.qw, s.qx};
        do @(posedge aclk); while (!s_tready);
        torque_queue.push_back(torque_of(s));
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (torque_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        drain();
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_GAIN:    angle_gain    = longint'(signed'(val));
            REG_RATE_GAIN:     rate_gain     = longint'(signed'(val));
            REG_STALL_TORQUE:  stall_torque  = val[30:0];
            REG_NO_LOAD_SPEED: no_load_speed = val[30:0];
            REG_GRAVITY:       gravity       = val[30:0];
            REG_ARM_LEN:       arm_len       = val[30:0];
            REG_TAKEOFF_GAIN:  takeoff_gain  = val[30:0];
            default:           speed_epsilon = val[30:0];
        endcase
    endtask

    function automatic logic signed [17:0] unit_q();
        return 18'($urandom_range(0, 131072)) - 18'sd65536;
    endfunction

    function automatic logic signed [31:0] wide_or_small(input int small_span);
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 2 * small_span) - small_span;
    endfunction

    // airborne samples are slower than grounded ones, so keep them rare
    function automatic sample_t random_sample(input bit flying);
        sample_t s;
        s.qx = unit_q();
        s.qw = unit_q();
        s.arm_rate = wide_or_small(1 << 20);
        s.fly_rate = wide_or_small(1 << 23);
        s.vel_y    = wide_or_small(1 << 18);
        s.vel_z    = wide_or_small(1 << 19);
        s.pos_z    = wide_or_small(1 << 17);
        s.pos_y    = wide_or_small(1 << 18);
        s.track_y  = ($urandom_range(0, 5) == 0) ? s.pos_y : wide_or_small(1 << 18);
        s.contact  = !flying;
        s.joints   = $urandom_range(0, 3) != 0;
        s.effort   = ($urandom_range(0, 2) == 0) ? $urandom
                                                 : $urandom_range(0, 200) - 60;
        return s;
    endfunction

    function automatic sample_t base_sample();
        sample_t s;
        s = '{default: '0};
        s.qw = 18'sd65536;
        s.contact = 1'b1;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // tests
    task automatic test_field_extremes();
        sample_t s;
        s = base_sample();
        send_sample(s);
        s.qw = -18'sd65536; s.qx = -18'sd65536; send_sample(s);
        s.qw = 18'sd0;      s.qx = 18'sd65536;  send_sample(s);
        s.qw = 18'sd1;      s.qx = -18'sd1;     send_sample(s);
        s.arm_rate = 32'h7FFF_FFFF; s.fly_rate = 32'h8000_0000; send_sample(s);
        s.arm_rate = 32'h8000_0000; s.fly_rate = 32'h7FFF_FFFF; send_sample(s);
        s.fly_rate = 32'd0; s.arm_rate = 32'sd65536;            send_sample(s);
    endtask

    task automatic test_takeoff_aim();
        sample_t s;
        s = base_sample();
        s.joints = 1'b1;
        s.effort = EFFORT_THRESH;      send_sample(s);   // at threshold: not extending
        s.effort = EFFORT_THRESH + 1;  s.track_y = 32'sd20000; send_sample(s);
        s.track_y = -32'sd20000;       send_sample(s);
        s.track_y = 32'sd0;            send_sample(s);   // zero offset
        s.track_y = 32'h7FFF_FFFF; s.pos_y = 32'h8000_0000; send_sample(s);
        s.effort = 32'h7FFF_FFFF; s.joints = 1'b0; send_sample(s);
    endtask

    task automatic test_airborne();
        sample_t s;
        s = base_sample();
        s.contact = 1'b0;
        s.vel_y = 32'sd65536; s.vel_z = 32'sd131072; s.pos_z = 32'sd65536;
        send_sample(s);
        s.vel_y = -32'sd40000; send_sample(s);
        s.vel_y = 32'sd66; send_sample(s);                       // vertical landing
        s.vel_y = 32'sd65536; s.vel_z = 32'h8000_0000; s.pos_z = 32'h7FFF_FFFF;
        send_sample(s);                                         // apex saturates
        s.vel_z = 32'sd0; s.pos_z = -32'sd1000; send_sample(s); // apex below zero
        s.contact = 1'b1; send_sample(s);                       // keep held angle
    endtask

    task automatic test_register_settings();
        sample_t s;
        write_reg(REG_GRAVITY, 32'd1);
        write_reg(REG_TAKEOFF_GAIN, 32'd1);
        write_reg(REG_SPEED_EPS, 32'h7FFF_FFFF);
        s = base_sample();
        s.contact = 1'b0; s.vel_z = 32'h7FFF_FFFF; s.vel_y = 32'sd5000;
        send_sample(s);
        s.contact = 1'b1; s.joints = 1'b1; s.effort = 32'sd1000; s.track_y = 32'sd3;
        send_sample(s);
        write_reg(REG_SPEED_EPS, 32'd0);
        write_reg(REG_ANGLE_GAIN, 32'h8000_0000);
        write_reg(REG_RATE_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_STALL_TORQUE, 32'h7FFF_FFFF);
        write_reg(REG_NO_LOAD_SPEED, 32'h7FFF_FFFF);
        write_reg(REG_ARM_LEN, 32'h7FFF_FFFF);
        write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
        write_reg(REG_TAKEOFF_GAIN, 32'h7FFF_FFFF);
        s = base_sample();
        s.arm_rate = 32'h8000_0000; send_sample(s);
        s.contact = 1'b0; s.vel_y = -32'sd1; s.vel_z = 32'sd70000; s.pos_z = 32'sd300;
        send_sample(s);
        write_reg(REG_NO_LOAD_SPEED, 32'd1);
        write_reg(REG_STALL_TORQUE, 32'd0);
        s = base_sample(); s.qw = 18'sd0; send_sample(s);
    endtask

    // random phases, each under a fresh register set
    task automatic test_random(input int n);
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_ANGLE_GAIN, (phase == 0) ? 32'd65536 : $urandom);
            write_reg(REG_RATE_GAIN, (phase == 0) ? 32'd524 : $urandom);
            write_reg(REG_STALL_TORQUE, (phase == 0) ? 32'd48038 : $urandom);
            write_reg(REG_NO_LOAD_SPEED, (phase == 0) ? 32'd80982835
                                                      : $urandom_range(1, 32'h7FFF_FFFF));
            write_reg(REG_GRAVITY, (phase == 0) ? 32'd642253 : $urandom_range(1, 1 << 22));
            write_reg(REG_ARM_LEN, (phase == 0) ? 32'd13107 : $urandom_range(1, 1 << 18));
            write_reg(REG_TAKEOFF_GAIN, $urandom_range(1, 1 << 18));
            write_reg(REG_SPEED_EPS, $urandom_range(0, 300));
            for (int k = 0; k < n / 5; k++) begin
                if (phase == 4 && k > n / 10) quiet = 1'b1;
                if (k == n / 20) drain();              // hold off until all results are in
                send_sample(random_sample($urandom_range(0, 14) == 0));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (torque_queue.size() == 0) begin
                $error("unexpected torque_command transaction %h", m_tdata);
                errors++;
            end else if (torque_queue[0] !== m_tdata) begin
                $error("torque_command expected %h actual %h", torque_queue[0], m_tdata);
                errors++;
                void'(torque_queue.pop_front());
            end else begin
                void'(torque_queue.pop_front());
            end
        end
    end

    // result-side back-pressure in random bursts
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        quiet = 1'b0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        cfg_we = 1'b0; cfg_index = REG_ANGLE_GAIN; cfg_wdata = '0;
        angle_gain = 65536; rate_gain = 524; stall_torque = 48038;
        no_load_speed = 80982835; gravity = 642253; arm_len = 13107;
        takeoff_gain = 65536; speed_epsilon = 66; held_landing = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_takeoff_aim();
        test_airborne();
        test_register_settings();
        test_random(1500);

        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
